@@ hw/rtl/c_escape_unescaper_unit_assert.svh @@
// Assertion macros for the escape decoder checker.
// All macros sample on clk_i and are disabled while rst_ni is low.
`ifndef C_ESCAPE_UNESCAPER_UNIT_ASSERT_SVH
`define C_ESCAPE_UNESCAPER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CEU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("c_escape_unescaper_unit: assertion failed");

// Next-cycle implication.
`define CEU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("c_escape_unescaper_unit: assertion failed");

`endif

@@ hw/rtl/ceu_pkg.sv @@
// ----------------------------------------------------------------------------
// ceu_pkg
// Shared types, character codes and helper functions of the escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ceu_pkg;

  // Result queue sizing: up to ResMax results per input beat.
  localparam int unsigned ResMax = 3;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Character codes
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChSeven  = 8'h37;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpF    = 8'h46;
  localparam logic [7:0] ChLoA    = 8'h61;
  localparam logic [7:0] ChLoB    = 8'h62;
  localparam logic [7:0] ChLoF    = 8'h66;
  localparam logic [7:0] ChLoN    = 8'h6E;
  localparam logic [7:0] ChLoR    = 8'h72;
  localparam logic [7:0] ChLoT    = 8'h74;
  localparam logic [7:0] ChLoV    = 8'h76;
  localparam logic [7:0] ChLoX    = 8'h78;
  localparam logic [7:0] ChUpX    = 8'h58;

  // Control codes produced by the letter escapes
  localparam logic [7:0] CtlBel = 8'd7;
  localparam logic [7:0] CtlBs  = 8'd8;
  localparam logic [7:0] CtlFf  = 8'd12;
  localparam logic [7:0] CtlLf  = 8'd10;
  localparam logic [7:0] CtlCr  = 8'd13;
  localparam logic [7:0] CtlHt  = 8'd9;
  localparam logic [7:0] CtlVt  = 8'd11;

  // One result beat
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       eos;
  } ceu_res_t;

  // Results of one input beat, first result in res[0]
  typedef struct packed {
    logic [1:0]            cnt;
    ceu_res_t [ResMax-1:0] res;
  } ceu_push_t;

  function automatic logic is_oct_f(logic [7:0] c);
    return (c >= ChZero) && (c <= ChSeven);
  endfunction

  function automatic logic is_hex_f(logic [7:0] c);
    return ((c >= ChZero) && (c <= ChNine)) ||
           ((c >= ChUpA) && (c <= ChUpF)) ||
           ((c >= ChLoA) && (c <= ChLoF));
  endfunction

  // Digit value; letters map through their low nibble plus nine
  function automatic logic [3:0] hex_val_f(logic [7:0] c);
    logic [3:0] v;
    if (c <= ChNine) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  // Append one data byte to a result list, drop it when full
  function automatic ceu_push_t push_f(ceu_push_t l, logic [7:0] b);
    ceu_push_t r;
    ceu_res_t  e;
    r = l;
    e.data       = b;
    e.byte_valid = 1'b1;
    e.eos        = 1'b0;
    unique case (l.cnt)
      2'd0:    r.res[0] = e;
      2'd1:    r.res[1] = e;
      2'd2:    r.res[2] = e;
      default: r.res    = l.res;
    endcase
    if (l.cnt != 2'd3) begin
      r.cnt = l.cnt + 2'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ceu_decoder.sv @@
// ----------------------------------------------------------------------------
// ceu_decoder
// Escape scanner state and the single-pass decode of one registered byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ceu_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output ceu_pkg::ceu_push_t push_o
);
  import ceu_pkg::*;

  // Scanner modes
  localparam logic [1:0] ModePlain = 2'd0;
  localparam logic [1:0] ModeEsc   = 2'd1;
  localparam logic [1:0] ModeOct   = 2'd2;
  localparam logic [1:0] ModeHex   = 2'd3;

  logic [1:0] mode_q, mode_d;
  logic [1:0] cnt_q, cnt_d;
  logic       up_q, up_d;
  logic [7:0] h0_q, h0_d;
  logic [7:0] h1_q, h1_d;
  ceu_push_t  list;
  logic       replay;

  // Decode one byte against the current mode
  always_comb begin
    list   = '0;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    up_d   = up_q;
    h0_d   = h0_q;
    h1_d   = h1_q;
    replay = 1'b0;

    unique case (mode_q)
      ModeEsc: begin
        mode_d = ModePlain;
        unique case (byte_i)
          ChLoA: list = push_f(list, CtlBel);
          ChLoB: list = push_f(list, CtlBs);
          ChLoF: list = push_f(list, CtlFf);
          ChLoN: list = push_f(list, CtlLf);
          ChLoR: list = push_f(list, CtlCr);
          ChLoT: list = push_f(list, CtlHt);
          ChLoV: list = push_f(list, CtlVt);
          ChLoX, ChUpX: begin
            mode_d = ModeHex;
            cnt_d  = 2'd0;
            up_d   = (byte_i == ChUpX);
          end
          default: begin
            if (is_oct_f(byte_i)) begin
              mode_d = ModeOct;
              h0_d   = byte_i;
              cnt_d  = 2'd1;
            end else begin
              list = push_f(list, byte_i);
            end
          end
        endcase
      end
      ModeOct: begin
        if (is_oct_f(byte_i) && (cnt_q < 2'd2)) begin
          h1_d  = byte_i;
          cnt_d = 2'd2;
        end else if (is_oct_f(byte_i)) begin
          list   = push_f(list, {h0_q[1:0], h1_q[2:0], byte_i[2:0]});
          mode_d = ModePlain;
          cnt_d  = 2'd0;
          up_d   = 1'b0;
        end else begin
          // Short run: held digits go out as text, byte is rescanned
          list = push_f(list, h0_q);
          if (cnt_q == 2'd2) begin
            list = push_f(list, h1_q);
          end
          mode_d = ModePlain;
          cnt_d  = 2'd0;
          up_d   = 1'b0;
          replay = 1'b1;
        end
      end
      ModeHex: begin
        if (is_hex_f(byte_i) && (cnt_q == 2'd0)) begin
          h0_d  = byte_i;
          cnt_d = 2'd1;
        end else if (is_hex_f(byte_i)) begin
          list   = push_f(list, {hex_val_f(h0_q), hex_val_f(byte_i)});
          mode_d = ModePlain;
          cnt_d  = 2'd0;
          up_d   = 1'b0;
        end else begin
          // Short run: letter and any held digit go out as text
          list = push_f(list, up_q ? ChUpX : ChLoX);
          if (cnt_q != 2'd0) begin
            list = push_f(list, h0_q);
          end
          mode_d = ModePlain;
          cnt_d  = 2'd0;
          up_d   = 1'b0;
          replay = 1'b1;
        end
      end
      ModePlain: begin
        replay = 1'b1;
      end
    endcase

    // Plain text handling
    if (replay) begin
      if (byte_i == ChBslash) begin
        mode_d = ModeEsc;
      end else begin
        list = push_f(list, byte_i);
      end
    end

    // Flush a pending sequence at end of string and mark the last beat
    if (last_i) begin
      if (mode_d == ModeOct) begin
        if (cnt_d >= 2'd2) begin
          list = push_f(list, {2'b00, h0_d[2:0], h1_d[2:0]});
        end else begin
          list = push_f(list, {5'b00000, h0_d[2:0]});
        end
      end else if (mode_d == ModeHex) begin
        if (cnt_d != 2'd0) begin
          list = push_f(list, {4'b0000, hex_val_f(h0_d)});
        end else begin
          list = push_f(list, up_d ? ChUpX : ChLoX);
        end
      end
      mode_d = ModePlain;
      cnt_d  = 2'd0;
      up_d   = 1'b0;
      unique case (list.cnt)
        2'd0: begin
          list.res[0].data       = 8'd0;
          list.res[0].byte_valid = 1'b0;
          list.res[0].eos        = 1'b1;
          list.cnt               = 2'd1;
        end
        2'd1:    list.res[0].eos = 1'b1;
        2'd2:    list.res[1].eos = 1'b1;
        default: list.res[2].eos = 1'b1;
      endcase
    end
  end

  // Drive results only on a decoded beat
  always_comb begin
    push_o = list;
    if (!fire_i) begin
      push_o.cnt = 2'd0;
    end
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModePlain;
      cnt_q  <= 2'd0;
      up_q   <= 1'b0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      up_q   <= up_d;
    end
  end

  // Hold digit bytes
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      h0_q <= h0_d;
      h1_q <= h1_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ceu_res_queue.sv @@
// ----------------------------------------------------------------------------
// ceu_res_queue
// Shifting result queue: takes up to three results per cycle, drains one beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ceu_res_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ceu_pkg::ceu_push_t push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ceu_pkg::ceu_res_t  head_o
);
  import ceu_pkg::*;

  ceu_res_t         slot_q [QDepth];
  ceu_res_t         slot_d [QDepth];
  logic [QCntW-1:0] count_q, count_d;
  logic [QCntW-1:0] base;
  logic             pop;

  assign pop    = (count_q != '0) && !out_stall_i;
  assign base   = count_q - QCntW'(pop);
  assign room_o = (count_q <= QCntW'(QDepth - ResMax));

  // Shift out the head, then drop new results in behind the survivors
  always_comb begin
    slot_d = slot_q;
    if (pop) begin
      for (int j = 0; j < QDepth - 1; j++) begin
        slot_d[j] = slot_q[j + 1];
      end
    end
    for (int j = 0; j < QDepth; j++) begin
      for (int k = 0; k < ResMax; k++) begin
        if ((2'(k) < push_i.cnt) && ((base + QCntW'(k)) == QCntW'(j))) begin
          slot_d[j] = push_i.res[k];
        end
      end
    end
    count_d = base + QCntW'(push_i.cnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign out_valid_o = (count_q != '0);
  assign head_o      = slot_q[0];

endmodule

`default_nettype wire

@@ hw/rtl/c_escape_unescaper_unit.sv @@
// ----------------------------------------------------------------------------
// c_escape_unescaper_unit
// C string escape decoder: one source byte in, zero to three decoded bytes out.
// ----------------------------------------------------------------------------
// A source byte accepted into the input register is decoded from it once the
// result queue has room, and its results are written into the queue, whose head
// drives the outputs. The block takes one byte per cycle as long as each byte
// yields at most one result and the output is not stalled. A byte that yields
// two or three results stalls the input while the queue drains. The four-entry
// result queue drains one beat per cycle unless out_stall_i is high, and the
// input register waits until the queue has room for three more results.
// The last byte of a string always ends with a beat marked end_of_string,
// which carries byte_valid low when that byte produced no data.
`default_nettype none

module c_escape_unescaper_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_of_string_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       end_of_string_o
);
  import ceu_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       accept;
  logic       fire;
  logic       room;
  ceu_push_t  push;
  ceu_res_t   head;

  // Decode the held beat once the queue can take its results
  assign fire       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= in_byte_i;
      in_last_q <= last_of_string_i;
    end
  end

  ceu_decoder u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .push_o (push)
  );

  ceu_res_queue u_res_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign out_byte_o      = head.data;
  assign byte_valid_o    = head.byte_valid;
  assign end_of_string_o = head.eos;

endmodule

`default_nettype wire

@@ hw/rtl/ceu_checker.sv @@
// ----------------------------------------------------------------------------
// ceu_checker
// Port-level checks of the escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "c_escape_unescaper_unit_assert.svh"

module ceu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       byte_valid_o,
  input logic       end_of_string_o
);

  // Hold a stalled result beat
  `CEU_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o) && $stable(byte_valid_o) && $stable(end_of_string_o))

  // An empty beat is only the end marker
  `CEU_ASSERT_IMP(a_empty_is_end, out_valid_o && !byte_valid_o, end_of_string_o && (out_byte_o == 8'd0))

  // Stall only with a beat in hand from an earlier accept or stall
  `CEU_ASSERT_IMP(a_stall_cause, in_stall_o, $past(in_valid_i && !in_stall_o) || $past(in_stall_o))

  // Input stalls only while results are waiting
  `CEU_ASSERT_IMP(a_stall_backlog, in_stall_o, out_valid_o)

endmodule

bind c_escape_unescaper_unit ceu_checker u_ceu_checker (.*);

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the C string escape decoder. A behavioral decoder
// predicts the decoded beats of every accepted source byte. Each output beat
// is checked in order against the oldest prediction while both channels
// idle and hold off at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import ceu_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned TailCycles = 16;

  typedef enum logic [1:0] {
    SCAN_PLAIN,
    SCAN_ESC,
    SCAN_OCT,
    SCAN_HEX
  } scan_e;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       eos;
  } beat_t;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic [7:0] in_byte_i        = 8'h00;
  logic       last_of_string_i = 1'b0;
  logic       out_stall_i      = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       end_of_string_o;

  // Decoder state of the predictor
  scan_e      mode_q;
  logic [7:0] held_q [2];
  int         held_n;
  bit         upper_q;

  beat_t       decoded_q[$];
  beat_t       item_beats[$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned sent_cnt;
  int unsigned beat_cnt;
  bit          tx_idle;
  bit          rx_idle;
  int unsigned rx_wait;
  int unsigned rx_hold;

  c_escape_unescaper_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .last_of_string_i(last_of_string_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .end_of_string_o (end_of_string_o)
  );

  always #4 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb: timeout after %0d cycles", cycle_cnt);
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("tb: mismatch: %s", what);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic bit is_octal(logic [7:0] c);
    return (c >= ChZero) && (c <= ChSeven);
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= ChZero && c <= ChNine) return c - ChZero;
    if (c >= ChUpA && c <= ChUpF) return c - ChUpA + 10;
    if (c >= ChLoA && c <= ChLoF) return c - ChLoA + 10;
    return -1;
  endfunction

  // Append one data beat, drop it beyond three
  function automatic void add_byte(logic [7:0] b);
    beat_t e;
    e.data       = b;
    e.byte_valid = 1'b1;
    e.eos        = 1'b0;
    if (item_beats.size() < 3) item_beats.push_back(e);
  endfunction

  function automatic void clear_scan();
    mode_q  = SCAN_PLAIN;
    held_n  = 0;
    upper_q = 1'b0;
  endfunction

  function automatic void plain_text(logic [7:0] c);
    if (c == ChBslash) mode_q = SCAN_ESC;
    else add_byte(c);
  endfunction

  // Decode one source byte and queue the beats it completes
  task automatic decode_source_byte(input logic [7:0] c, input logic last);
    int    d0;
    int    d1;
    int    d2;
    beat_t e;
    item_beats = {};
    case (mode_q)
      SCAN_ESC: begin
        mode_q = SCAN_PLAIN;
        case (c)
          ChLoA: add_byte(CtlBel);
          ChLoB: add_byte(CtlBs);
          ChLoF: add_byte(CtlFf);
          ChLoN: add_byte(CtlLf);
          ChLoR: add_byte(CtlCr);
          ChLoT: add_byte(CtlHt);
          ChLoV: add_byte(CtlVt);
          ChLoX, ChUpX: begin
            mode_q  = SCAN_HEX;
            held_n  = 0;
            upper_q = (c == ChUpX);
          end
          default: begin
            if (is_octal(c)) begin
              mode_q    = SCAN_OCT;
              held_q[0] = c;
              held_n    = 1;
            end else begin
              add_byte(c);
            end
          end
        endcase
      end
      SCAN_OCT: begin
        if (is_octal(c) && held_n < 2) begin
          held_q[1] = c;
          held_n    = 2;
        end else if (is_octal(c)) begin
          d0 = held_q[0] - ChZero;
          d1 = held_q[1] - ChZero;
          d2 = c - ChZero;
          add_byte(8'((d0 << 6) | (d1 << 3) | d2));
          clear_scan();
        end else begin
          // Short run: give the held digits back as text
          for (int i = 0; i < held_n && i < 2; i++) add_byte(held_q[i]);
          clear_scan();
          plain_text(c);
        end
      end
      SCAN_HEX: begin
        if (hex_digit(c) >= 0 && held_n == 0) begin
          held_q[0] = c;
          held_n    = 1;
        end else if (hex_digit(c) >= 0) begin
          add_byte(8'((hex_digit(held_q[0]) << 4) | hex_digit(c)));
          clear_scan();
        end else begin
          add_byte(upper_q ? ChUpX : ChLoX);
          if (held_n != 0) add_byte(held_q[0]);
          clear_scan();
          plain_text(c);
        end
      end
      default: plain_text(c);
    endcase

    // End of string: flush a partial run, drop a pending backslash
    if (last) begin
      if (mode_q == SCAN_OCT) begin
        d0 = held_q[0] - ChZero;
        d1 = held_q[1] - ChZero;
        if (held_n >= 2) add_byte(8'((d0 << 3) | d1));
        else add_byte(8'(d0));
      end else if (mode_q == SCAN_HEX) begin
        if (held_n != 0) add_byte(8'(hex_digit(held_q[0])));
        else add_byte(upper_q ? ChUpX : ChLoX);
      end
      clear_scan();
      if (item_beats.size() == 0) begin
        e.data       = 8'h00;
        e.byte_valid = 1'b0;
        e.eos        = 1'b1;
        item_beats.push_back(e);
      end else begin
        item_beats[item_beats.size() - 1].eos = 1'b1;
      end
    end
    foreach (item_beats[i]) decoded_q.push_back(item_beats[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Offer one beat after a random gap when tx_idle is set and hold it until accepted
  task automatic send_beat(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    in_byte_i        <= b;
    last_of_string_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    decode_source_byte(b, last);
    sent_cnt++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], i == s.len() - 1);
  endtask

  // Drop valid and hold until every predicted beat has come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: hold off per beat, or for a long stretch on request
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      out_stall_i <= 1'b1;
      rx_hold--;
    end else if (rx_wait != 0) begin
      out_stall_i <= 1'b1;
      rx_wait--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check each accepted output beat against the oldest prediction
  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rx_wait = rx_idle ? $urandom_range(0, 8) : 0;
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("beat %0d unexpected, out_byte %02h", beat_cnt, out_byte_o));
      end else begin
        want = decoded_q.pop_front();
        if (out_byte_o !== want.data)
          report_mismatch($sformatf("beat %0d out_byte got %02h want %02h",
                                    beat_cnt, out_byte_o, want.data));
        if (byte_valid_o !== want.byte_valid)
          report_mismatch($sformatf("beat %0d byte_valid got %b want %b",
                                    beat_cnt, byte_valid_o, want.byte_valid));
        if (end_of_string_o !== want.eos)
          report_mismatch($sformatf("beat %0d end_of_string got %b want %b",
                                    beat_cnt, end_of_string_o, want.eos));
      end
      beat_cnt++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_letter_escapes();
    send_text("\\a\\b\\f\\n\\r\\t\\v\\\\");
  endtask

  // Full run with wrap, short run of two, partial run at end of string
  task automatic test_octal_runs();
    send_text("\\777\\12z");
    send_text("\\12");
  endtask

  // Mixed case digits, short run of one, bare letter at end of string
  task automatic test_hex_runs();
    send_text("\\xFf\\X9g");
    send_text("\\x");
  endtask

  // Trailing backslash, escaped NUL and escaped 0xFF
  task automatic test_end_cases();
    send_text("\\");
    send_beat(ChBslash, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(ChBslash, 1'b0);
    send_beat(8'hFF, 1'b1);
  endtask

  // Stall the output long enough to back up the input, then drain
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_hold = 120;
    send_text("\\101\\x4AZ\\12q\\Xe\\q\\777\\1");
    wait_drained();
    tx_idle = 1'b1;
  endtask

  // Build one string from random escape tokens and send it
  task automatic send_random_string();
    logic [7:0] str_q[$];
    logic [7:0] letters[7];
    string      hex_chars;
    int         tokens;
    int         n;
    int         pick;
    letters   = '{ChLoA, ChLoB, ChLoF, ChLoN, ChLoR, ChLoT, ChLoV};
    hex_chars = "0123456789ABCDEFabcdef";
    tokens    = $urandom_range(1, 6);
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        str_q.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 45) begin
        str_q.push_back(ChBslash);
        str_q.push_back(letters[$urandom_range(0, 6)]);
      end else if (pick < 65) begin
        str_q.push_back(ChBslash);
        n = $urandom_range(1, 4);
        repeat (n) str_q.push_back(8'(ChZero + $urandom_range(0, 7)));
      end else if (pick < 85) begin
        str_q.push_back(ChBslash);
        str_q.push_back($urandom_range(0, 1) ? ChUpX : ChLoX);
        n = $urandom_range(0, 3);
        repeat (n) str_q.push_back(hex_chars[$urandom_range(0, 21)]);
      end else if (pick < 95) begin
        str_q.push_back(ChBslash);
        str_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        str_q.push_back(ChBslash);
      end
    end
    foreach (str_q[i]) send_beat(str_q[i], i == str_q.size() - 1);
  endtask

  // Random strings, idling switched on and off per string
  task automatic test_random_strings();
    int unsigned start;
    start = sent_cnt;
    while (sent_cnt - start < 115) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      send_random_string();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    clear_scan();
    held_q[0] = 8'h00;
    held_q[1] = 8'h00;
    err_cnt   = 0;
    cycle_cnt = 0;
    sent_cnt  = 0;
    beat_cnt  = 0;
    rx_wait   = 0;
    rx_hold   = 0;
    tx_idle   = 1'b1;
    rx_idle   = 1'b1;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_letter_escapes();
    test_octal_runs();
    test_hex_runs();
    test_end_cases();
    test_backpressure();
    test_random_strings();

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
